// ===== design/cx_pkg.sv =====
// Shared types and constants for the cycle crossover block.
// No dependencies; used by every module under design/.
package cx_pkg;

   localparam int unsigned MAX_GENES = 64;
   localparam int unsigned GENE_W    = $clog2(MAX_GENES);
   localparam int unsigned LEN_W     = GENE_W + 1;
   localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_GENES);

   typedef logic [GENE_W-1:0] gene_type;
   typedef logic [LEN_W-1:0]  len_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_WALK_A,
      ST_WALK_B,
      ST_WALK_C,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } cx_state_type;

   // one result item on its way to the output register
   typedef struct packed {
      gene_type position;
      gene_type gene_a;
      gene_type gene_b;
      logic     mark;
      logic     last;
   } cx_emit_type;

endpackage

// ===== design/cx_lane.sv =====
// One gene lane: a 64 x 6 store with one write port and one registered read port.
// Depends on cx_pkg.
module cx_lane (
   input  logic              clock,
   input  logic              wr_en,
   input  cx_pkg::gene_type  wr_addr,
   input  cx_pkg::gene_type  wr_data,
   input  logic              rd_en,
   input  cx_pkg::gene_type  rd_addr,
   output cx_pkg::gene_type  rd_data
);

   cx_pkg::gene_type store_ff [cx_pkg::MAX_GENES];
   cx_pkg::gene_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cx_merge.sv =====
// Merge stage: picks child genes from the two lanes by the cycle mark and holds
// the result item in the output register. Depends on cx_pkg.
module cx_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                emit_load,
   input  cx_pkg::cx_emit_type emit,
   output logic                emit_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cx_pkg::gene_type    rsp_position,
   output cx_pkg::gene_type    rsp_child_a_gene,
   output cx_pkg::gene_type    rsp_child_b_gene,
   output logic                rsp_last
);

   logic             valid_ff, valid_in;
   cx_pkg::gene_type pos_ff, child_a_ff, child_b_ff;
   logic             last_ff;

   assign emit_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (emit_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         pos_ff     <= emit.position;
         child_a_ff <= emit.mark ? emit.gene_a : emit.gene_b;
         child_b_ff <= emit.mark ? emit.gene_b : emit.gene_a;
         last_ff    <= emit.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_position     = pos_ff;
   assign rsp_child_a_gene = child_a_ff;
   assign rsp_child_b_gene = child_b_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== design/cycle_crossover.sv =====
// Cycle crossover top level: load sequencer, cycle walk, emit sequencer.
// Depends on cx_pkg, cx_lane and cx_merge.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------
//  req     | req_gene_a, req_gene_b, req_start_pos   | req_valid / req_ready
//  rsp     | rsp_position, rsp_child_*_gene, rsp_last| rsp_valid / rsp_ready
//  csr     | csr_wr_data (genome_length)             | csr_wr_en, no wait
//
// Loading writes each accepted item into the lanes, with no wait between items. The item
// completing the parents starts a run: for each cycle position the walk reads lane A,
// then the inverse map, then checks for the start position; then each result is read from
// the lanes and then loaded into the output register, which waits while rsp stalls.
// req_ready is high only while loading. No clearing pass after reset.
module cycle_crossover (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cx_pkg::gene_type req_gene_a,
   input  cx_pkg::gene_type req_gene_b,
   input  cx_pkg::gene_type req_start_pos,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cx_pkg::gene_type rsp_position,
   output cx_pkg::gene_type rsp_child_a_gene,
   output cx_pkg::gene_type rsp_child_b_gene,
   output logic             rsp_last,
   input  logic             csr_wr_en,
   input  cx_pkg::len_type  csr_wr_data
);

   cx_pkg::cx_state_type state_ff, state_in;
   cx_pkg::len_type      len_ff;
   cx_pkg::gene_type     count_ff, count_in;
   cx_pkg::gene_type     wp_ff, wp_in;
   cx_pkg::gene_type     start_ff, start_in;
   cx_pkg::len_type      steps_ff, steps_in;
   cx_pkg::gene_type     idx_ff, idx_in;
   logic [cx_pkg::MAX_GENES-1:0] mark_ff, mark_in;

   cx_pkg::len_type     count_sum, len_m1, steps_sum, idx_sum;
   cx_pkg::gene_type    start_c;
   logic                load_wr;
   logic                a_rd_en, b_rd_en, inv_rd_en;
   cx_pkg::gene_type    a_rd_addr;
   cx_pkg::gene_type    a_rd_data, b_rd_data, inv_rd_data;
   logic                emit_load, emit_free;
   cx_pkg::cx_emit_type emit;

   assign count_sum = {1'b0, count_ff} + cx_pkg::LEN_W'(1);
   assign steps_sum = steps_ff + cx_pkg::LEN_W'(1);
   assign idx_sum   = {1'b0, idx_ff} + cx_pkg::LEN_W'(1);
   assign len_m1    = len_ff - cx_pkg::LEN_W'(1);
   assign start_c   = ({1'b0, req_start_pos} >= len_ff) ? len_m1[cx_pkg::GENE_W-1:0]
                                                        : req_start_pos;
   assign load_wr   = req_valid && req_ready;

   assign emit.position = idx_ff;
   assign emit.gene_a   = a_rd_data;
   assign emit.gene_b   = b_rd_data;
   assign emit.mark     = mark_ff[idx_ff];
   assign emit.last     = (idx_sum == len_ff);

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      a_rd_en   = 1'b0;
      b_rd_en   = 1'b0;
      inv_rd_en = 1'b0;
      a_rd_addr = idx_ff;
      emit_load = 1'b0;
      count_in  = count_ff;
      wp_in     = wp_ff;
      start_in  = start_ff;
      steps_in  = steps_ff;
      idx_in    = idx_ff;
      mark_in   = mark_ff;
      case (state_ff)
         cx_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_sum >= len_ff) begin
                  count_in = '0;
                  mark_in  = '0;
                  wp_in    = start_c;
                  start_in = start_c;
                  steps_in = '0;
                  state_in = cx_pkg::ST_WALK_A;
               end else begin
                  count_in = count_sum[cx_pkg::GENE_W-1:0];
               end
            end
         end
         cx_pkg::ST_WALK_A: begin
            a_rd_en        = 1'b1;
            a_rd_addr      = wp_ff;
            mark_in[wp_ff] = 1'b1;
            state_in       = cx_pkg::ST_WALK_B;
         end
         cx_pkg::ST_WALK_B: begin
            inv_rd_en = 1'b1;
            state_in  = cx_pkg::ST_WALK_C;
         end
         cx_pkg::ST_WALK_C: begin
            steps_in = steps_sum;
            if (inv_rd_data == start_ff || steps_sum == len_ff) begin
               idx_in   = '0;
               state_in = cx_pkg::ST_EMIT_RD;
            end else begin
               wp_in    = inv_rd_data;
               state_in = cx_pkg::ST_WALK_A;
            end
         end
         cx_pkg::ST_EMIT_RD: begin
            a_rd_en  = 1'b1;
            b_rd_en  = 1'b1;
            state_in = cx_pkg::ST_EMIT_OUT;
         end
         cx_pkg::ST_EMIT_OUT: begin
            if (emit_free) begin
               emit_load = 1'b1;
               if (emit.last) begin
                  state_in = cx_pkg::ST_LOAD;
               end else begin
                  idx_in   = idx_sum[cx_pkg::GENE_W-1:0];
                  state_in = cx_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = cx_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cx_pkg::ST_LOAD;
         count_ff <= '0;
         wp_ff    <= '0;
         start_ff <= '0;
         steps_ff <= '0;
         idx_ff   <= '0;
         mark_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         wp_ff    <= wp_in;
         start_ff <= start_in;
         steps_ff <= steps_in;
         idx_ff   <= idx_in;
         mark_ff  <= mark_in;
      end
   end

   // length register, saturated into the legal range
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= cx_pkg::LEN_MAX;
      end else if (csr_wr_en) begin
         if (csr_wr_data < cx_pkg::LEN_MIN) begin
            len_ff <= cx_pkg::LEN_MIN;
         end else if (csr_wr_data > cx_pkg::LEN_MAX) begin
            len_ff <= cx_pkg::LEN_MAX;
         end else begin
            len_ff <= csr_wr_data;
         end
      end
   end

   cx_lane u_lane_a (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (count_ff),
      .wr_data (req_gene_a),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   cx_lane u_lane_b (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (count_ff),
      .wr_data (req_gene_b),
      .rd_en   (b_rd_en),
      .rd_addr (idx_ff),
      .rd_data (b_rd_data)
   );

   // inverse map of parent B: gene -> position
   cx_lane u_lane_inv (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_gene_b),
      .wr_data (count_ff),
      .rd_en   (inv_rd_en),
      .rd_addr (a_rd_data),
      .rd_data (inv_rd_data)
   );

   cx_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .emit_load        (emit_load),
      .emit             (emit),
      .emit_free        (emit_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_child_a_gene (rsp_child_a_gene),
      .rsp_child_b_gene (rsp_child_b_gene),
      .rsp_last         (rsp_last)
   );

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cx_pkg::ST_WALK_A || state_ff == cx_pkg::ST_WALK_B ||
       state_ff == cx_pkg::ST_WALK_C) |-> (steps_ff < len_ff))
      else $error("walk ran past genome length");

   a_start_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cx_pkg::ST_EMIT_RD && $past(state_ff) == cx_pkg::ST_WALK_C)
      |-> mark_ff[start_ff])
      else $error("start position not marked after walk");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cx_pkg::ST_EMIT_RD || state_ff == cx_pkg::ST_EMIT_OUT)
      |-> ({1'b0, idx_ff} < len_ff))
      else $error("emit index beyond genome length");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> ({1'b0, rsp_position} == len_m1))
      else $error("last item not at final position");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for cycle_crossover: feeds parent gene pairs and genome_length
// writes, and checks every child result against a cycle crossover predictor in the bench or typed expected children.
// Depends on cx_pkg and the cycle_crossover RTL.
module tb_top;
   import cx_pkg::*;

   localparam int LIMIT_CYCLES   = 300000;
   localparam int ITEMS_PER_MODE = 62;
   localparam int MAX_SHOWN      = 30;
   localparam int N_ROWS         = 16;
   localparam int PERM_W         = GENE_W * MAX_GENES;

   typedef struct packed {
      gene_type position;
      gene_type child_a;
      gene_type child_b;
      logic     last;
   } offspring_type;

   // typed children hold up to three genes, position 0 in the low bits
   typedef struct packed {
      logic        do_cfg;
      len_type     cfg_raw;
      gene_type    gene_a;
      gene_type    gene_b;
      gene_type    start;
      logic        typed;
      logic [17:0] want_a;
      logic [17:0] want_b;
   } pair_row_type;

   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     req_valid     = 1'b0;
   logic     req_ready;
   gene_type req_gene_a    = '0;
   gene_type req_gene_b    = '0;
   gene_type req_start_pos = '0;
   logic     rsp_valid;
   logic     rsp_ready     = 1'b0;
   gene_type rsp_position;
   gene_type rsp_child_a_gene;
   gene_type rsp_child_b_gene;
   logic     rsp_last;
   logic     csr_wr_en     = 1'b0;
   len_type  csr_wr_data   = '0;

   always #4 clock = ~clock;

   cycle_crossover i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_gene_a       (req_gene_a),
      .req_gene_b       (req_gene_b),
      .req_start_pos    (req_start_pos),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_child_a_gene (rsp_child_a_gene),
      .rsp_child_b_gene (rsp_child_b_gene),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   gene_type      par_a    [MAX_GENES];
   gene_type      par_b    [MAX_GENES];
   gene_type      b_pos_of [MAX_GENES];
   logic          on_cycle [MAX_GENES];
   int unsigned   pairs_held;
   int unsigned   genome_len;
   offspring_type offspring_q [$];

   int           send_idle = 10;
   int           recv_idle = 71;
   int           errors    = 0;
   int           shown     = 0;
   int           n_items   = 0;
   int           n_results = 0;
   int           n_runs    = 0;
   int           n_cfg     = 0;
   int           cycle_count = 0;
   pair_row_type dir_rows [N_ROWS];

   task automatic breed_pair(input gene_type ga, input gene_type gb, input gene_type sp,
                             input logic typed, input logic [17:0] want_a,
                             input logic [17:0] want_b);
      int unsigned   slot;
      int unsigned   start;
      int unsigned   p;
      int unsigned   i;
      offspring_type r;
      slot = pairs_held % MAX_GENES;
      par_a[slot] = ga;
      par_b[slot] = gb;
      b_pos_of[gb] = gene_type'(slot);
      pairs_held++;
      if (pairs_held >= genome_len) begin
         pairs_held = 0;
         n_runs++;
         for (i = 0; i < MAX_GENES; i++) on_cycle[i] = 1'b0;
         start = (sp >= genome_len) ? genome_len - 1 : sp;
         p = start;
         for (i = 0; i < genome_len; i++) begin
            on_cycle[p] = 1'b1;
            p = b_pos_of[par_a[p]];
            if (p == start) break;
         end
         for (i = 0; i < genome_len; i++) begin
            r.position = gene_type'(i);
            r.child_a  = on_cycle[i] ? par_a[i] : par_b[i];
            r.child_b  = on_cycle[i] ? par_b[i] : par_a[i];
            if (typed) begin
               r.child_a = want_a[GENE_W*i +: GENE_W];
               r.child_b = want_b[GENE_W*i +: GENE_W];
            end
            r.last = (i + 1 == genome_len);
            offspring_q.push_back(r);
         end
      end
   endtask

   task automatic send_item(input gene_type ga, input gene_type gb, input gene_type sp,
                            input logic typed, input logic [17:0] want_a,
                            input logic [17:0] want_b);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid     <= 1'b1;
      req_gene_a    <= ga;
      req_gene_b    <= gb;
      req_start_pos <= sp;
      do @(posedge clock); while (!req_ready);
      n_items++;
      breed_pair(ga, gb, sp, typed, want_a, want_b);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (offspring_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_genome_length(input len_type raw);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= raw;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      genome_len = (raw < LEN_MIN) ? LEN_MIN : (raw > LEN_MAX) ? LEN_MAX : raw;
      n_cfg++;
   endtask

   function automatic logic [PERM_W-1:0] random_perm(input int unsigned n);
      logic [PERM_W-1:0] v;
      gene_type          t;
      int unsigned       i;
      int unsigned       j;
      v = '0;
      for (i = 0; i < n; i++) v[GENE_W*i +: GENE_W] = gene_type'(i);
      for (i = n - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = v[GENE_W*i +: GENE_W];
         v[GENE_W*i +: GENE_W] = v[GENE_W*j +: GENE_W];
         v[GENE_W*j +: GENE_W] = t;
      end
      return v;
   endfunction

   function automatic gene_type random_start();
      if ($urandom_range(1)) return gene_type'($urandom_range(genome_len - 1));
      return gene_type'($urandom_range(63));
   endfunction

   // fill the remaining slots of the current load; noisy parents need not be permutations
   task automatic load_parents(input logic noisy);
      logic [PERM_W-1:0] pa;
      logic [PERM_W-1:0] pb;
      int unsigned       k;
      int unsigned       first;
      pa = random_perm(genome_len);
      pb = random_perm(genome_len);
      first = (pairs_held < genome_len) ? pairs_held : genome_len - 1;
      for (k = first; k < genome_len; k++) begin
         if (noisy)
            send_item(gene_type'($urandom_range(63)), gene_type'($urandom_range(63)),
                      random_start(), 1'b0, '0, '0);
         else
            send_item(pa[GENE_W*k +: GENE_W], pb[GENE_W*k +: GENE_W], random_start(),
                      1'b0, '0, '0);
      end
   endtask

   // part of a load, then a new length while pairs are held
   task automatic broken_load();
      logic [PERM_W-1:0] pa;
      logic [PERM_W-1:0] pb;
      int unsigned       k;
      int unsigned       cnt;
      pa  = random_perm(genome_len);
      pb  = random_perm(genome_len);
      cnt = $urandom_range(genome_len - 1, 1);
      for (k = 0; k < cnt; k++)
         send_item(pa[GENE_W*k +: GENE_W], pb[GENE_W*k +: GENE_W], random_start(),
                   1'b0, '0, '0);
      set_genome_length(len_type'($urandom_range(12)));
   endtask

   always @(posedge clock) begin
      offspring_type got;
      offspring_type want;
      cycle_count++;
      got = {rsp_position, rsp_child_a_gene, rsp_child_b_gene, rsp_last};
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (offspring_q.size() == 0) begin
            errors++;
            if (shown < MAX_SHOWN)
               $display("%0t: unexpected item: pos %0d a %0d b %0d last %0b", $time,
                        got.position, got.child_a, got.child_b, got.last);
            shown++;
         end else begin
            want = offspring_q.pop_front();
            if (got !== want) begin
               errors++;
               if (shown < MAX_SHOWN)
                  $display({"%0t: mismatch: expected pos %0d a %0d b %0d last %0b,",
                            " got pos %0d a %0d b %0d last %0b"}, $time,
                           want.position, want.child_a, want.child_b, want.last,
                           got.position, got.child_a, got.child_b, got.last);
               shown++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("%0t: timeout, %0d items still expected", $time, offspring_q.size());
      $display("tb_top failed");
      $finish;
   end

   initial begin
      int          r;
      int          mode;
      int          quota;
      int unsigned pick;
      pairs_held = 0;
      genome_len = MAX_GENES;
      for (r = 0; r < MAX_GENES; r++) on_cycle[r] = 1'b0;
      dir_rows = '{
         '{1'b1, 7'd0, 6'd0, 6'd1, 6'd63, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd1, 6'd0, 6'd0, 1'b1, {6'd0, 6'd1, 6'd0}, {6'd0, 6'd0, 6'd1}},
         '{1'b1, 7'd3, 6'd0, 6'd1, 6'd63, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd1, 6'd0, 6'd63, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd2, 6'd2, 6'd2, 1'b1, {6'd2, 6'd0, 6'd1}, {6'd2, 6'd1, 6'd0}},
         '{1'b0, 7'd0, 6'd2, 6'd1, 6'd0, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd0, 6'd2, 6'd0, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd1, 6'd0, 6'd63, 1'b1, {6'd1, 6'd0, 6'd2}, {6'd0, 6'd2, 6'd1}},
         '{1'b1, 7'd5, 6'd0, 6'd0, 6'd63, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd1, 6'd1, 6'd63, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd2, 6'd2, 6'd63, 1'b0, 18'd0, 18'd0},
         '{1'b1, 7'd1, 6'd3, 6'd3, 6'd0, 1'b1, {6'd0, 6'd1, 6'd0}, {6'd0, 6'd1, 6'd0}},
         '{1'b1, 7'd4, 6'd3, 6'd0, 6'd63, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd2, 6'd1, 6'd63, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd1, 6'd2, 6'd63, 1'b0, 18'd0, 18'd0},
         '{1'b0, 7'd0, 6'd0, 6'd3, 6'd1, 1'b0, 18'd0, 18'd0}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < N_ROWS; r++) begin
         if (dir_rows[r].do_cfg) set_genome_length(dir_rows[r].cfg_raw);
         send_item(dir_rows[r].gene_a, dir_rows[r].gene_b, dir_rows[r].start,
                   dir_rows[r].typed, dir_rows[r].want_a, dir_rows[r].want_b);
      end

      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle = 10;
               recv_idle = 71;
            end
            1: begin
               send_idle = 71;
               recv_idle = 10;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         quota = n_items + ITEMS_PER_MODE;
         // one full-size permutation writes every store entry before any noise
         if (mode == 0) begin
            set_genome_length(7'd127);
            load_parents(1'b0);
            set_genome_length(len_type'($urandom_range(12, 3)));
         end
         while (n_items < quota) begin
            pick = $urandom_range(9);
            if (pick == 0)
               set_genome_length(len_type'($urandom_range(2)));
            else if (pick < 3)
               set_genome_length(len_type'($urandom_range(12, 3)));
            if (pick == 9 && genome_len > 2 && pairs_held == 0)
               broken_load();
            else
               load_parents(pick == 8);
         end
      end

      wait_quiet();
      repeat (24) @(posedge clock);
      $display("%0d gene pairs over %0d crossover runs, %0d length writes", n_items, n_runs,
               n_cfg);
      $display("%0d child items checked, %0d errors", n_results, errors);
      if (errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
